// ===== sv/scad_pkg.sv =====
// types and constants shared by the sprite chain attribute decoder
// no dependencies; compile first
package scad_pkg;

   localparam int POS_W = 10;

   // csr register indexes
   localparam logic CSR_FLIP_SCREEN = 1'b0;
   localparam logic CSR_X_OFFSET    = 1'b1;

   // position constants, 10-bit two's complement except the 9-bit x wrap limit
   localparam logic [8:0]       X_WRAP_LIMIT = 9'd496;
   localparam logic [POS_W-1:0] X_WRAP_SUB   = 10'h200;
   localparam logic [POS_W-1:0] Y_ORIGIN     = 10'd256;
   localparam logic [POS_W-1:0] TILE_H       = 10'd16;
   localparam logic [POS_W-1:0] FS_Y_BASE    = 10'd240;
   localparam logic [POS_W-1:0] FS_X_BASE    = 10'd304;

   typedef struct packed {
      logic       flip_screen;
      logic [3:0] x_offset;
   } cfg_type;

   // input item, first field in the highest bits
   typedef struct packed {
      logic [7:0] x_byte;
      logic [3:0] colour_nibble;
      logic [7:0] tile_high_byte;
      logic [7:0] tile_low_byte;
      logic [7:0] attr_byte;
      logic [7:0] y_byte;
   } item_type;

   typedef struct packed {
      logic                    last_tile;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_x;
      logic                    flip_y;
      logic                    flip_x;
      logic [3:0]              colour_bank;
      logic [15:0]             tile_number;
   } tile_cmd_type;

endpackage

// ===== sv/sprite_chain_attribute_decoder.sv =====
// steps on the single shared adder: capture in idle, x wrap, x offset, y negate, y lift,
// flipped-only y, y offset and x steps, y start, emit, then the output register
// no new entry until its chain (length 1..8) is out; disabled entries are dropped in idle
// reset: synchronous, active high; clears the sequencer, output valid and both csr registers
// depends on scad_pkg, scad_seq, scad_alu
module sprite_chain_attribute_decoder (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // y_byte, attr_byte, tile_low_byte, tile_high_byte, colour_nibble, x_byte, pad
   input  logic [47:0] req_tdata,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tile_number, colour_bank, flip_x, flip_y, pos_x, pos_y, pad
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [3:0]  csr_data
);

   scad_pkg::cfg_type      cfg_ff;
   scad_pkg::item_type     item;
   scad_pkg::tile_cmd_type cmd;
   scad_pkg::tile_cmd_type rsp_ff;
   logic                   rsp_valid_ff;
   logic                   cmd_valid;
   logic                   slot_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            scad_pkg::CSR_FLIP_SCREEN: cfg_ff.flip_screen <= csr_data[0];
            scad_pkg::CSR_X_OFFSET:    cfg_ff.x_offset    <= csr_data;
            default:                   cfg_ff             <= cfg_ff;
         endcase
      end
   end

   assign item = scad_pkg::item_type'(req_tdata[43:0]);

   scad_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (item),
      .cmd_valid (cmd_valid),
      .cmd_ready (slot_free),
      .cmd       (cmd)
   );

   // output register frees the sequencer from the response side
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid && slot_free) begin
         rsp_ff <= cmd;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.last_tile;
   assign rsp_tdata  = {6'b000000, rsp_ff.pos_y, rsp_ff.pos_x, rsp_ff.flip_y,
                        rsp_ff.flip_x, rsp_ff.colour_bank, rsp_ff.tile_number};

endmodule

// ===== sv/scad_alu.sv =====
// shared 10-bit adder with carry in, used for every position step
// depends on scad_pkg
module scad_alu (
   input  logic [scad_pkg::POS_W-1:0] a,
   input  logic [scad_pkg::POS_W-1:0] b,
   input  logic                       cin,
   output logic [scad_pkg::POS_W-1:0] sum
);

   assign sum = a + b + {{(scad_pkg::POS_W-1){1'b0}}, cin};

endmodule

// ===== sv/scad_seq.sv =====
// sequencer: decodes one sprite entry over several adder steps, then emits its chain
// depends on scad_pkg and scad_alu
module scad_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  scad_pkg::cfg_type      cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  scad_pkg::item_type     in_item,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output scad_pkg::tile_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_X_WRAP,
      ST_X_OFF,
      ST_Y_NEG,
      ST_Y_LIFT,
      ST_FS_Y,
      ST_FS_YOFF,
      ST_FS_X,
      ST_Y_START,
      ST_EMIT
   } state_type;

   state_type                  state_ff;
   logic [scad_pkg::POS_W-1:0] x_ff;
   logic [scad_pkg::POS_W-1:0] y_ff;
   logic [15:0]                tile_ff;
   logic [3:0]                 colour_ff;
   logic                       fx_ff;
   logic                       fy_ff;
   logic [2:0]                 chain_ff;
   logic [2:0]                 k_ff;

   logic [scad_pkg::POS_W-1:0] alu_a;
   logic [scad_pkg::POS_W-1:0] alu_b;
   logic                       alu_cin;
   logic [scad_pkg::POS_W-1:0] alu_sum;
   logic [scad_pkg::POS_W-1:0] chain_span;
   logic [scad_pkg::POS_W-1:0] off_ext;

   assign chain_span = {3'b000, chain_ff, 4'b0000};
   assign off_ext    = {6'b000000, cfg.x_offset};

   scad_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .cin (alu_cin),
      .sum (alu_sum)
   );

   always_comb begin
      alu_a   = y_ff;
      alu_b   = '0;
      alu_cin = 1'b0;
      case (state_ff)
         ST_X_WRAP: begin
            alu_a = x_ff;
            alu_b = (x_ff[8:0] > scad_pkg::X_WRAP_LIMIT) ? scad_pkg::X_WRAP_SUB : '0;
         end
         ST_X_OFF: begin
            alu_a = x_ff;
            alu_b = off_ext;
         end
         ST_Y_NEG: begin
            alu_a   = scad_pkg::Y_ORIGIN;
            alu_b   = ~y_ff;
            alu_cin = 1'b1;
         end
         ST_Y_LIFT: begin
            alu_b   = ~scad_pkg::TILE_H;
            alu_cin = 1'b1;
         end
         ST_FS_Y: begin
            alu_a   = scad_pkg::FS_Y_BASE;
            alu_b   = ~y_ff;
            alu_cin = 1'b1;
         end
         ST_FS_YOFF: begin
            alu_b   = ~off_ext;
            alu_cin = 1'b1;
         end
         ST_FS_X: begin
            alu_a   = scad_pkg::FS_X_BASE;
            alu_b   = ~x_ff;
            alu_cin = 1'b1;
         end
         ST_Y_START: begin
            // chain starts at the far end when the step runs against screen order
            if (fy_ff ^ cfg.flip_screen) begin
               alu_b   = fy_ff ? ~chain_span : chain_span;
               alu_cin = fy_ff;
            end
         end
         ST_EMIT: begin
            alu_b   = fy_ff ? scad_pkg::TILE_H : ~scad_pkg::TILE_H;
            alu_cin = ~fy_ff;
         end
         default: begin
            alu_a = y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  x_ff      <= {1'b0, in_item.attr_byte[2], in_item.x_byte};
                  y_ff      <= {1'b0, in_item.attr_byte[1], in_item.y_byte};
                  tile_ff   <= {in_item.tile_high_byte, in_item.tile_low_byte};
                  colour_ff <= in_item.colour_nibble;
                  fx_ff     <= in_item.attr_byte[4] ^ cfg.flip_screen;
                  fy_ff     <= in_item.attr_byte[3] ^ cfg.flip_screen;
                  chain_ff  <= in_item.attr_byte[7:5];
                  k_ff      <= '0;
                  // disabled entry is dropped
                  state_ff  <= in_item.attr_byte[0] ? ST_X_WRAP : ST_IDLE;
               end
            end
            ST_X_WRAP: begin
               x_ff     <= alu_sum;
               state_ff <= ST_X_OFF;
            end
            ST_X_OFF: begin
               x_ff     <= alu_sum;
               state_ff <= ST_Y_NEG;
            end
            ST_Y_NEG: begin
               y_ff     <= {1'b0, alu_sum[8:0]};
               state_ff <= ST_Y_LIFT;
            end
            ST_Y_LIFT: begin
               y_ff     <= alu_sum;
               state_ff <= cfg.flip_screen ? ST_FS_Y : ST_Y_START;
            end
            ST_FS_Y: begin
               y_ff     <= alu_sum;
               state_ff <= ST_FS_YOFF;
            end
            ST_FS_YOFF: begin
               y_ff     <= alu_sum;
               state_ff <= ST_FS_X;
            end
            ST_FS_X: begin
               x_ff     <= alu_sum;
               state_ff <= ST_Y_START;
            end
            ST_Y_START: begin
               y_ff     <= alu_sum;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (cmd_ready) begin
                  y_ff    <= alu_sum;
                  tile_ff <= tile_ff + 16'd1;
                  k_ff    <= k_ff + 3'd1;
                  if (k_ff == chain_ff) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign cmd_valid = (state_ff == ST_EMIT);

   always_comb begin
      cmd.tile_number = tile_ff;
      cmd.colour_bank = colour_ff;
      cmd.flip_x      = fx_ff;
      cmd.flip_y      = fy_ff;
      cmd.pos_x       = signed'(x_ff);
      cmd.pos_y       = signed'(y_ff);
      cmd.last_tile   = (k_ff == chain_ff);
   end

endmodule

// ===== sim/tb_sprite_chain_attribute_decoder.sv =====
// self-checking testbench for sprite_chain_attribute_decoder
// predicts the tile command run of every sprite entry and checks each response transaction
// depends on scad_pkg and the decoder rtl
`timescale 1ns / 1ps

module tb_sprite_chain_attribute_decoder;

   localparam int CLK_HALF     = 6;
   localparam int DRAIN_CYCLES = 30;
   localparam int LONG_HOLD    = 150;
   localparam int X_WRAP       = 496;
   localparam int X_SPAN       = 512;
   localparam int Y_TOP        = 256;
   localparam int TILE_STEP    = 16;
   localparam int FLIP_Y_BASE  = 240;
   localparam int FLIP_X_BASE  = 304;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = scad_pkg::CSR_FLIP_SCREEN;
   logic [3:0]  csr_data   = '0;

   scad_pkg::item_type     entry_queue[$];
   scad_pkg::tile_cmd_type pending_tiles[$];
   scad_pkg::item_type     drive_item;
   int           gap_left    = 0;
   int           stall_left  = 0;
   int           hold_left   = 0;
   bit           hold_done   = 1'b0;
   logic         hold_req    = 1'b0;
   logic         calm        = 1'b0;
   bit           cfg_flip_screen = 1'b0;
   logic [3:0]   cfg_x_offset    = '0;
   int           error_count = 0;

   sprite_chain_attribute_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // expected tile commands for one sprite entry under the current screen settings
   task automatic predict_tiles(input scad_pkg::item_type it);
      int          xp;
      int          yp;
      int          yk;
      int          len;
      logic        fx;
      logic        fy;
      logic [15:0] base;
      scad_pkg::tile_cmd_type cmd;
      if (it.attr_byte[0]) begin
         xp = int'({it.attr_byte[2], it.x_byte});
         if (xp > X_WRAP) xp -= X_SPAN;
         xp += int'(cfg_x_offset);
         yp = ((Y_TOP - int'({it.attr_byte[1], it.y_byte})) & 511) - TILE_STEP;
         fx = it.attr_byte[4];
         fy = it.attr_byte[3];
         len = int'(it.attr_byte[7:5]) + 1;
         base = {it.tile_high_byte, it.tile_low_byte};
         if (cfg_flip_screen) begin
            fx = !fx;
            fy = !fy;
            yp = FLIP_Y_BASE - yp - int'(cfg_x_offset);
            xp = FLIP_X_BASE - xp;
         end
         for (int k = 0; k < len; k++) begin
            if (cfg_flip_screen)
               yk = fy ? yp + TILE_STEP * k : yp + TILE_STEP * (len - 1) - TILE_STEP * k;
            else
               yk = fy ? yp - TILE_STEP * (len - 1) + TILE_STEP * k : yp - TILE_STEP * k;
            cmd.tile_number = base + 16'(k);
            cmd.colour_bank = it.colour_nibble;
            cmd.flip_x      = fx;
            cmd.flip_y      = fy;
            cmd.pos_x       = xp[9:0];
            cmd.pos_y       = yk[9:0];
            cmd.last_tile   = (k == len - 1);
            pending_tiles.push_back(cmd);
         end
      end
   endtask

   function automatic int field_miss(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // sender: one entry transaction at a time, random gaps between them
   always @(posedge clock) begin : entry_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_tiles(drive_item);
            offer = 1'b0;
            if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 9);
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (entry_queue.size() > 0) begin
               drive_item = entry_queue.pop_front();
               req_tdata <= {4'b0, drive_item};
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // receiver: checks every tile command, stalls in bursts and once for a long stretch
   always @(posedge clock) begin : tile_monitor
      scad_pkg::tile_cmd_type got;
      scad_pkg::tile_cmd_type want;
      int           misses;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tlast, rsp_tdata[41:0]};
            if (pending_tiles.size() == 0) begin
               $display("%0t ns: unexpected tile command, expected none, actual %0h",
                        $time, got);
               error_count++;
            end else begin
               want = pending_tiles.pop_front();
               misses = field_miss("tile_number", want.tile_number, got.tile_number)
                      + field_miss("colour_bank", 16'(want.colour_bank),
                                   16'(got.colour_bank))
                      + field_miss("flip_x", 16'(want.flip_x), 16'(got.flip_x))
                      + field_miss("flip_y", 16'(want.flip_y), 16'(got.flip_y))
                      + field_miss("pos_x", 16'(want.pos_x), 16'(got.pos_x))
                      + field_miss("pos_y", 16'(want.pos_y), 16'(got.pos_y))
                      + field_miss("last_tile", 16'(want.last_tile), 16'(got.last_tile));
               if (misses != 0) error_count++;
            end
         end
         if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_entry(input logic [7:0] y, input logic [7:0] attr,
                             input logic [7:0] tlo, input logic [7:0] thi,
                             input logic [3:0] col, input logic [7:0] x);
      scad_pkg::item_type it;
      it.y_byte         = y;
      it.attr_byte      = attr;
      it.tile_low_byte  = tlo;
      it.tile_high_byte = thi;
      it.colour_nibble  = col;
      it.x_byte         = x;
      entry_queue.push_back(it);
   endtask

   // mostly enabled entries, biased toward the x wrap point and tile overflow
   task automatic push_random(input int count);
      scad_pkg::item_type it;
      repeat (count) begin
         it.y_byte         = 8'($urandom_range(0, 255));
         it.attr_byte      = 8'($urandom_range(0, 255));
         it.tile_low_byte  = 8'($urandom_range(0, 255));
         it.tile_high_byte = 8'($urandom_range(0, 255));
         it.colour_nibble  = 4'($urandom_range(0, 15));
         it.x_byte         = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 7) != 0) it.attr_byte[0] = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            it.attr_byte[2] = 1'b1;
            it.x_byte = 8'($urandom_range(236, 255));
         end
         if ($urandom_range(0, 7) == 0) begin
            it.tile_high_byte = 8'hff;
            it.tile_low_byte  = 8'($urandom_range(248, 255));
         end
         entry_queue.push_back(it);
      end
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == scad_pkg::CSR_FLIP_SCREEN) cfg_flip_screen = val[0];
      else cfg_x_offset = val;
   endtask

   task automatic set_screen(input bit flip, input logic [3:0] offset);
      write_csr(scad_pkg::CSR_FLIP_SCREEN, {3'b0, flip});
      write_csr(scad_pkg::CSR_X_OFFSET, offset);
   endtask

   // every queued entry sent and every tile command back, then let the pipe settle
   task automatic wait_drained();
      do @(negedge clock);
      while (entry_queue.size() != 0 || req_tvalid || pending_tiles.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_screen(1'b0, 4'd0);
      push_entry(8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00);   // disabled
      push_entry(8'hff, 8'hfe, 8'hff, 8'hff, 4'hf, 8'hff);   // disabled, all else set
      push_entry(8'h00, 8'h01, 8'h00, 8'h00, 4'h0, 8'h00);
      push_entry(8'hff, 8'hff, 8'hff, 8'hff, 4'hf, 8'hff);   // all ones, tile wraps
      push_entry(8'h10, 8'he1, 8'hfc, 8'hff, 4'h5, 8'h80);   // tile overflow mid chain
      push_entry(8'h40, 8'h05, 8'h12, 8'h34, 4'h3, 8'hf0);   // x at 496, no wrap
      push_entry(8'h40, 8'h05, 8'h12, 8'h34, 4'h3, 8'hf1);   // x wraps negative
      push_entry(8'h40, 8'h05, 8'h12, 8'h34, 4'h3, 8'hff);
      push_entry(8'h00, 8'h03, 8'h01, 8'h00, 4'h1, 8'h20);   // y msb set
      push_entry(8'h01, 8'h03, 8'h01, 8'h00, 4'h1, 8'h20);
      push_entry(8'hff, 8'h01, 8'h02, 8'h00, 4'h2, 8'h20);
      push_entry(8'h80, 8'h49, 8'h10, 8'h00, 4'h7, 8'h40);   // flip y, chain 3
      push_entry(8'h80, 8'h31, 8'h20, 8'h00, 4'h8, 8'h40);   // flip x, chain 2
      push_entry(8'h80, 8'h79, 8'h30, 8'h01, 4'h9, 8'h40);   // both flips, chain 4
      push_entry(8'h90, 8'h81, 8'h40, 8'h02, 4'ha, 8'h60);   // chain 5
      push_entry(8'h90, 8'ha1, 8'h50, 8'h03, 4'hb, 8'h60);   // chain 6
      push_entry(8'h90, 8'hc1, 8'h60, 8'h04, 4'hc, 8'h60);   // chain 7
      push_entry(8'h90, 8'hed, 8'h70, 8'h05, 4'hd, 8'h60);   // chain 8, x msb, flip y
      wait_drained();

      set_screen(1'b1, 4'd15);
      push_entry(8'h00, 8'h01, 8'h00, 8'h00, 4'h0, 8'h00);
      push_entry(8'hff, 8'hff, 8'hff, 8'hff, 4'hf, 8'hff);
      push_entry(8'h40, 8'h05, 8'h12, 8'h34, 4'h3, 8'hf1);
      push_entry(8'h00, 8'h03, 8'h01, 8'h00, 4'h1, 8'h20);
      push_entry(8'h80, 8'h49, 8'h10, 8'h00, 4'h7, 8'h40);
      push_random(45);
      wait_drained();

      // receiver holds off long enough for the decoder to back up into its input
      set_screen(1'b0, 4'd15);
      push_random(50);
      hold_req <= 1'b1;
      wait_drained();

      // sender pauses mid phase until all results are back
      set_screen(1'b1, 4'd0);
      push_random(25);
      wait_drained();
      push_random(25);
      wait_drained();

      set_screen(1'b1, 4'($urandom_range(1, 14)));
      push_random(45);
      wait_drained();

      calm <= 1'b1;
      set_screen(1'b0, 4'($urandom_range(1, 14)));
      push_random(50);
      wait_drained();

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #(2 * CLK_HALF * 200000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
